/* design/ddp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pkg
// Shared types and binary64 arithmetic helpers for the four-lane dot product.
// ----------------------------------------------------------------------------
package ddp_pkg;

	localparam int LANES = 4;
	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [10:0] EXP_MAX = 11'h7FF;

	typedef logic [63:0] f64_t;

	// Per-transaction control that travels with the data
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} ctl_t;

	// Leading zero count, 64-bit word (nonzero input)
	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = 7'(63 - i);
		end
		return n;
	endfunction

	// Leading zero count, 106-bit product (nonzero input)
	function automatic logic [6:0] lzc106(input logic [105:0] v);
		logic [6:0] n;
		n = 7'd106;
		for (int i = 0; i < 106; i++) begin
			if (v[i]) n = 7'(105 - i);
		end
		return n;
	endfunction

	// Round to nearest even and pack. m has its leading one at bit 63 and
	// sticky folded into bit 0; e is the biased exponent of that leading one.
	function automatic f64_t fp_round(input logic s, input logic signed [13:0] e,
			input logic [63:0] m);
		logic [63:0] mm;
		logic [63:0] back;
		logic [13:0] sh;
		logic [53:0] rm;
		logic up;
		logic sub;
		logic signed [13:0] ef;
		logic [51:0] frac;
		mm = m;
		sub = (e <= 14'sd0);
		sh = 14'd1 - e;
		// tiny result: denormalize with sticky
		if (sub) begin
			if (sh > 14'd63) begin
				mm = {63'b0, |m};
			end else begin
				mm = m >> sh[5:0];
				back = mm << sh[5:0];
				mm[0] = mm[0] | (back != m);
			end
		end
		up = mm[10] & ((|mm[9:0]) | mm[11]);
		rm = {1'b0, mm[63:11]} + 54'(up);
		if (sub) begin
			ef = rm[52] ? 14'sd1 : 14'sd0;
			frac = rm[51:0];
		end else begin
			ef = e + 14'(rm[53]);
			frac = rm[53] ? 52'b0 : rm[51:0];
		end
		if (ef >= 14'sd2047) return {s, EXP_MAX, 52'b0};
		return {s, ef[10:0], frac};
	endfunction

	// binary64 add, round to nearest even, subnormals kept
	function automatic f64_t fp_add(input f64_t x, input f64_t y);
		logic [10:0] ex, ey, e1, e2;
		logic [52:0] mx, my, m1, m2;
		logic xn, yn, xi, yi, s1, s2, swap;
		logic [10:0] d;
		logic [63:0] big, small0, sm, back, r;
		logic [6:0] lz;
		logic signed [13:0] en;
		f64_t res;
		ex = x[62:52];
		ey = y[62:52];
		xn = (ex == EXP_MAX) && (|x[51:0]);
		yn = (ey == EXP_MAX) && (|y[51:0]);
		xi = (ex == EXP_MAX) && !(|x[51:0]);
		yi = (ey == EXP_MAX) && !(|y[51:0]);
		mx = {|ex, x[51:0]};
		my = {|ey, y[51:0]};
		if (ex == 11'd0) ex = 11'd1;
		if (ey == 11'd0) ey = 11'd1;
		// larger magnitude goes first
		swap = (y[62:0] > x[62:0]);
		s1 = swap ? y[63] : x[63];
		s2 = swap ? x[63] : y[63];
		e1 = swap ? ey : ex;
		e2 = swap ? ex : ey;
		m1 = swap ? my : mx;
		m2 = swap ? mx : my;
		d = e1 - e2;
		big = {1'b0, m1, 10'b0};
		small0 = {1'b0, m2, 10'b0};
		if (d > 11'd63) begin
			sm = {63'b0, |m2};
		end else begin
			sm = small0 >> d[5:0];
			back = sm << d[5:0];
			sm[0] = sm[0] | (back != small0);
		end
		r = (s1 == s2) ? big + sm : big - sm;
		lz = lzc64(r);
		en = 14'(e1) + 14'sd1 - 14'(lz);
		if (xn || yn || (xi && yi && (x[63] != y[63]))) begin
			res = CANON_NAN;
		end else if (xi) begin
			res = x;
		end else if (yi) begin
			res = y;
		end else if (r == 64'd0) begin
			res = {x[63] & y[63], 63'b0};
		end else begin
			res = fp_round(s1, en, r << lz);
		end
		return res;
	endfunction

endpackage

/* design/ddp_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_mul
// Four-stage binary64 multiplier: partial products, sum, normalize, round.
// ----------------------------------------------------------------------------
module ddp_mul import ddp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ctl_t ctl_in,
	input  f64_t a,
	input  f64_t b,
	output ctl_t ctl_out,
	output f64_t prod
);

	typedef struct packed {
		logic sign;
		logic nan;
		logic inf;
		logic zero;
	} mflags_t;

	logic [10:0] ea, eb;
	logic [52:0] ma, mb;
	mflags_t fl_in;
	logic signed [13:0] exp_in;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	mflags_t fl_s1, fl_s2, fl_s3;
	logic signed [13:0] exp_s1, exp_s2, exp_s3;
	logic [51:0] hh_s1;
	logic [52:0] hl_s1, lh_s1;
	logic [53:0] ll_s1;
	logic [105:0] prod_s2;
	logic [63:0] mant_s3;
	f64_t prod_s4;

	logic [6:0] lz;
	logic [105:0] norm;

	// operand decode
	always_comb begin
		ea = a[62:52];
		eb = b[62:52];
		ma = {|ea, a[51:0]};
		mb = {|eb, b[51:0]};
		fl_in.sign = a[63] ^ b[63];
		fl_in.zero = (ma == 53'd0) || (mb == 53'd0);
		fl_in.inf = (ea == EXP_MAX) || (eb == EXP_MAX);
		fl_in.nan = ((ea == EXP_MAX) && (|a[51:0])) || ((eb == EXP_MAX) && (|b[51:0]))
			|| (fl_in.inf && fl_in.zero);
		exp_in = 14'((ea == 11'd0) ? 11'd1 : ea) + 14'((eb == 11'd0) ? 11'd1 : eb)
			- 14'sd1023;
	end

	// normalize the raw product
	always_comb begin
		lz = lzc106(prod_s2);
		norm = prod_s2 << lz;
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s1 <= fl_in;
			exp_s1 <= exp_in;
			hh_s1 <= ma[52:27] * mb[52:27];
			hl_s1 <= ma[52:27] * mb[26:0];
			lh_s1 <= ma[26:0] * mb[52:27];
			ll_s1 <= ma[26:0] * mb[26:0];

			fl_s2 <= fl_s1;
			exp_s2 <= exp_s1;
			prod_s2 <= ({54'b0, hh_s1} << 54) + ({52'b0, 1'b0, hl_s1} << 27)
				+ ({52'b0, 1'b0, lh_s1} << 27) + {52'b0, ll_s1};

			fl_s3 <= fl_s2;
			exp_s3 <= exp_s2 + 14'sd1 - 14'(lz);
			mant_s3 <= {norm[105:43], |norm[42:0]};

			if (fl_s3.nan) prod_s4 <= CANON_NAN;
			else if (fl_s3.inf) prod_s4 <= {fl_s3.sign, EXP_MAX, 52'b0};
			else if (fl_s3.zero) prod_s4 <= {fl_s3.sign, 63'b0};
			else prod_s4 <= fp_round(fl_s3.sign, exp_s3, mant_s3);
		end
	end

	assign ctl_out = ctl_s4;
	assign prod = prod_s4;

endmodule

/* design/ddp_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_lane
// One lane: product pipeline feeding a binary64 accumulator.
// ----------------------------------------------------------------------------
module ddp_lane import ddp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ctl_t ctl_in,
	input  f64_t a,
	input  f64_t b,
	input  f64_t init,
	output ctl_t ctl_out,
	output f64_t sum
);

	ctl_t mctl;
	ctl_t ctl_s5;
	f64_t prod;
	f64_t init_s1, init_s2, init_s3, init_s4;
	f64_t acc_q;

	ddp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_in),
		.a       (a),
		.b       (b),
		.ctl_out (mctl),
		.prod    (prod)
	);

	// start value follows the product pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			init_s1 <= init;
			init_s2 <= init_s1;
			init_s3 <= init_s2;
			init_s4 <= init_s3;
		end
	end

	// accumulate; first transaction of a vector reloads the start value
	always_ff @(posedge clk) begin
		if (en && mctl.valid) begin
			acc_q <= fp_add(mctl.first ? init_s4 : acc_q, prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5 <= mctl;
		end
	end

	assign ctl_out = ctl_s5;
	assign sum = acc_q;

endmodule

/* design/ddp_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_merge
// Two-stage add tree: (lane0 + lane2) + (lane1 + lane3).
// ----------------------------------------------------------------------------
module ddp_merge import ddp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic go,
	input  f64_t lane_sum [LANES],
	output logic res_valid,
	output f64_t res
);

	logic v_s6, v_s7;
	f64_t s02_s6, s13_s6, res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= go;
			v_s7 <= v_s6;
		end
	end

	// pairwise sums, then final sum
	always_ff @(posedge clk) begin
		if (en) begin
			s02_s6 <= fp_add(lane_sum[0], lane_sum[2]);
			s13_s6 <= fp_add(lane_sum[1], lane_sum[3]);
			res_s7 <= fp_add(s02_s6, s13_s6);
		end
	end

	assign res_valid = v_s7;
	assign res = res_s7;

endmodule

/* design/double_dot_product_four_lane_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_dot_product_four_lane_unit
// Four-lane binary64 dot product with a start value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/stall): each transaction carries four (a, b) pairs,
//   a start value and last_group. The first transaction after reset or after
//   a last one opens a vector; lanes start at 0, 0, 0 and start_value.
//   Each lane adds its rounded product to its accumulator every transaction.
//   Output channel (result_valid/result_stall): one dot_result per vector,
//   (lane0 + lane2) + (lane1 + lane3), round to nearest even.
//   Throughput: one transaction per cycle while stall is low. The result of a last
//   transaction passes 4 multiply stages, the accumulator, and two add-tree
//   stages before it appears on dot_result.
//   Stall: the whole pipeline holds while a result waits in the output
//   register and result_stall is high; stall is raised then.
//   Reset: pipeline empty, no vector open.
// ----------------------------------------------------------------------------
module double_dot_product_four_lane_unit import ddp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic stall,
	input  logic [63:0] a_lane0,
	input  logic [63:0] a_lane1,
	input  logic [63:0] a_lane2,
	input  logic [63:0] a_lane3,
	input  logic [63:0] b_lane0,
	input  logic [63:0] b_lane1,
	input  logic [63:0] b_lane2,
	input  logic [63:0] b_lane3,
	input  logic [63:0] start_value,
	input  logic last_group,
	output logic result_valid,
	input  logic result_stall,
	output logic [63:0] dot_result
);

	logic en;
	logic in_vector_q;
	logic go;
	ctl_t ctl_in;
	f64_t a_arr [LANES];
	f64_t b_arr [LANES];
	f64_t sums [LANES];
	ctl_t lane_ctl [LANES];

	// pipeline moves unless a finished result is held
	assign en = !(result_valid && result_stall);
	assign stall = !en;

	assign a_arr = '{a_lane0, a_lane1, a_lane2, a_lane3};
	assign b_arr = '{b_lane0, b_lane1, b_lane2, b_lane3};

	always_comb begin
		ctl_in.valid = valid && en;
		ctl_in.first = !in_vector_q;
		ctl_in.last = last_group;
	end

	// vector tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vector_q <= 1'b0;
		end else if (valid && en) begin
			in_vector_q <= !last_group;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		ddp_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_in),
			.a       (a_arr[i]),
			.b       (b_arr[i]),
			.init    ((i == LANES - 1) ? start_value : 64'd0),
			.ctl_out (lane_ctl[i]),
			.sum     (sums[i])
		);
	end

	// merge once every lane has taken the last transaction
	always_comb begin
		go = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			go = go & lane_ctl[i].valid & lane_ctl[i].last;
		end
	end

	ddp_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.go        (go),
		.lane_sum  (sums),
		.res_valid (result_valid),
		.res       (dot_result)
	);

endmodule
